/* rtl/tcce_pkg.sv */
// Shared types and codes for the text console cell engine.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam logic [2:0] ACT_PUT        = 3'd0;
    localparam logic [2:0] ACT_BACKSPACE  = 3'd1;
    localparam logic [2:0] ACT_CLEAR      = 3'd2;
    localparam logic [2:0] ACT_READ       = 3'd3;
    localparam logic [2:0] ACT_SET_CURSOR = 3'd4;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CHAR   = 8'd0;

    localparam int         ADDR_W           = 3;
    localparam logic [0:0] REG_CLEAR_ATTR   = 1'b0;
    localparam logic [7:0] CLEAR_ATTR_RESET = 8'd15;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_SET_CURSOR
    } op_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  character;
        logic [7:0]  attribute;
        logic [10:0] position;
    } in_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  read_character;
        logic [7:0]  read_attribute;
        logic        scrolled;
    } out_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  character;
        logic [7:0]  attribute;
        logic [10:0] position;
        logic        in_range;
    } cmd_t;

endpackage

/* rtl/tcce_front.sv */
// Front end: accepts input transactions and decodes them into back-end commands.
`timescale 1ns / 1ps

module tcce_front #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic           item_valid,
    output logic           item_stall,
    input  tcce_pkg::in_t  item,
    input  logic           queue_full,
    input  logic           init_busy,
    output logic           push,
    output tcce_pkg::cmd_t cmd
);

    localparam int CELLS = ROWS * COLS;

    logic [10:0] pos_sat;
    logic        pos_in_range;

    assign item_stall   = queue_full || init_busy;
    assign push         = item_valid && !item_stall;
    assign pos_in_range = 32'(item.position) < 32'(CELLS);
    assign pos_sat      = (32'(item.position) > 32'(CELLS)) ? 11'(CELLS) : item.position;

    always_comb
    begin
        cmd.character = item.character;
        cmd.attribute = item.attribute;
        cmd.position  = item.position;
        cmd.in_range  = pos_in_range;
        case (item.action)
            tcce_pkg::ACT_PUT:
            begin
                cmd.op = (item.character == tcce_pkg::NEWLINE_CODE) ?
                         tcce_pkg::OP_NEWLINE : tcce_pkg::OP_PUT;
            end
            tcce_pkg::ACT_BACKSPACE:  cmd.op = tcce_pkg::OP_BACKSPACE;
            tcce_pkg::ACT_CLEAR:      cmd.op = tcce_pkg::OP_CLEAR;
            tcce_pkg::ACT_READ:       cmd.op = tcce_pkg::OP_READ;
            tcce_pkg::ACT_SET_CURSOR:
            begin
                cmd.op       = tcce_pkg::OP_SET_CURSOR;
                cmd.position = pos_sat;
            end
            default:                  cmd.op = tcce_pkg::OP_NOP;
        endcase
    end

endmodule

/* rtl/tcce_queue.sv */
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcce_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tcce_pkg::cmd_t head
);

    tcce_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/tcce_back.sv */
// Back end: cell store, cursor, sweep engine for scroll and clear, result register.
`timescale 1ns / 1ps

module tcce_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     clear_attr,
    input  logic           cmd_valid,
    input  tcce_pkg::cmd_t cmd,
    output logic           pop,
    output logic           init_busy,
    output logic           result_valid,
    input  logic           result_stall,
    output tcce_pkg::out_t result
);

    localparam int CELLS    = ROWS * COLS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(CELLS + 1);
    localparam int LAST_ROW = (ROWS - 1) * COLS;

    localparam logic [CW-1:0] CELLS_C    = CW'(CELLS);
    localparam logic [CW-1:0] LAST_ROW_C = CW'(LAST_ROW);
    localparam logic [CW-1:0] COLS_C     = CW'(COLS);
    localparam logic [AW-1:0] SCAN_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLS);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLS);
    localparam logic [AW-1:0] LAST_ROW_A = AW'(LAST_ROW);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_WALK  = 6'b000100,
        S_SWEEP = 6'b001000,
        S_FLUSH = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        SW_ZERO,
        SW_BLANK,
        SW_SCROLL
    } sweep_t;

    state_t         state_reg, state_next;
    sweep_t         kind_reg, kind_next;
    logic [CW-1:0]  cursor_reg, cursor_next;
    logic [CW-1:0]  base_reg, base_next;
    logic [AW-1:0]  scan_reg, scan_next;
    tcce_pkg::op_t  op_reg, op_next;
    logic [7:0]     chr_reg, chr_next;
    logic [7:0]     attr_reg, attr_next;
    logic           res_valid_reg, res_valid_next;
    tcce_pkg::out_t res_reg, res_next;

    logic           stg_pend_reg, stg_pend_next;
    logic           stg_copy_reg, stg_copy_next;
    logic [AW-1:0]  stg_addr_reg, stg_addr_next;
    logic [15:0]    stg_blank_reg, stg_blank_next;

    logic [15:0]    mem [CELLS];
    logic [15:0]    rdata_reg;
    logic           re;
    logic [AW-1:0]  raddr;
    logic           dwe;
    logic [AW-1:0]  dwaddr;
    logic [15:0]    dwdata;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [15:0]    wdata;

    logic           produce;
    logic [7:0]     rd_chr;
    logic [7:0]     rd_attr;
    logic           scr;
    logic [15:0]    blank;

    assign blank        = {clear_attr, tcce_pkg::BLANK_CHAR};
    assign init_busy    = (kind_reg == SW_ZERO) && (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cursor_next    = cursor_reg;
        base_next      = base_reg;
        scan_next      = scan_reg;
        op_next        = op_reg;
        chr_next       = chr_reg;
        attr_next      = attr_reg;
        stg_pend_next  = 1'b0;
        stg_copy_next  = 1'b0;
        stg_addr_next  = stg_addr_reg;
        stg_blank_next = stg_blank_reg;
        pop            = 1'b0;
        re             = 1'b0;
        raddr          = '0;
        dwe            = 1'b0;
        dwaddr         = '0;
        dwdata         = '0;
        produce        = 1'b0;
        rd_chr         = 8'd0;
        rd_attr        = 8'd0;
        scr            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (!res_valid_reg || !result_stall))
                begin
                    pop       = 1'b1;
                    op_next   = cmd.op;
                    chr_next  = cmd.character;
                    attr_next = cmd.attribute;
                    case (cmd.op)
                        tcce_pkg::OP_PUT:
                        begin
                            if (cursor_reg == CELLS_C)
                            begin
                                // past the end: scroll first, write after the sweep
                                kind_next  = SW_SCROLL;
                                scan_next  = '0;
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                dwe         = 1'b1;
                                dwaddr      = AW'(cursor_reg);
                                dwdata      = {cmd.attribute, cmd.character};
                                cursor_next = cursor_reg + CW'(1);
                                produce     = 1'b1;
                            end
                        end
                        tcce_pkg::OP_NEWLINE:
                        begin
                            if (cursor_reg >= LAST_ROW_C)
                            begin
                                kind_next  = SW_SCROLL;
                                scan_next  = '0;
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                base_next  = '0;
                                state_next = S_WALK;
                            end
                        end
                        tcce_pkg::OP_BACKSPACE:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - CW'(1);
                                dwe         = 1'b1;
                                dwaddr      = AW'(cursor_next);
                                dwdata      = blank;
                            end
                            produce = 1'b1;
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            kind_next  = SW_BLANK;
                            scan_next  = '0;
                            state_next = S_SWEEP;
                        end
                        tcce_pkg::OP_READ:
                        begin
                            if (cmd.in_range)
                            begin
                                re         = 1'b1;
                                raddr      = AW'(cmd.position);
                                state_next = S_READ;
                            end
                            else
                            begin
                                produce = 1'b1;
                            end
                        end
                        tcce_pkg::OP_SET_CURSOR:
                        begin
                            cursor_next = CW'(cmd.position);
                            produce     = 1'b1;
                        end
                        default:
                        begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_chr     = rdata_reg[7:0];
                rd_attr    = rdata_reg[15:8];
                produce    = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                // advance a row base until the next row start passes the cursor
                if (base_reg + COLS_C <= cursor_reg)
                begin
                    base_next = base_reg + COLS_C;
                end
                else
                begin
                    cursor_next = base_reg + COLS_C;
                    produce     = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                stg_pend_next  = 1'b1;
                stg_addr_next  = scan_reg;
                stg_blank_next = (kind_reg == SW_ZERO) ? 16'h0000 : blank;
                if ((kind_reg == SW_SCROLL) && (scan_reg < COPY_END))
                begin
                    re            = 1'b1;
                    raddr         = scan_reg + ROW_STEP;
                    stg_copy_next = 1'b1;
                end
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            S_FLUSH:
            begin
                // last staged write lands at this edge
                state_next = S_IDLE;
                case (kind_reg)
                    SW_ZERO:
                    begin
                        kind_next = SW_BLANK;
                    end
                    SW_BLANK:
                    begin
                        produce = 1'b1;
                    end
                    SW_SCROLL:
                    begin
                        cursor_next = LAST_ROW_C;
                        if (op_reg == tcce_pkg::OP_PUT)
                        begin
                            state_next = S_POST;
                        end
                        else
                        begin
                            scr     = 1'b1;
                            produce = 1'b1;
                        end
                    end
                    default:
                    begin
                        kind_next = SW_BLANK;
                    end
                endcase
            end
            S_POST:
            begin
                dwe         = 1'b1;
                dwaddr      = LAST_ROW_A;
                dwdata      = {attr_reg, chr_reg};
                cursor_next = LAST_ROW_C + CW'(1);
                scr         = 1'b1;
                produce     = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_valid_next = (res_valid_reg && result_stall) || produce;
        res_next       = res_reg;
        if (produce)
        begin
            res_next.cursor_pos     = 11'(cursor_next);
            res_next.read_character = rd_chr;
            res_next.read_attribute = rd_attr;
            res_next.scrolled       = scr;
        end
    end

    assign we    = stg_pend_reg || dwe;
    assign waddr = stg_pend_reg ? stg_addr_reg : dwaddr;
    assign wdata = stg_pend_reg ? (stg_copy_reg ? rdata_reg : stg_blank_reg) : dwdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            kind_reg      <= SW_ZERO;
            cursor_reg    <= '0;
            scan_reg      <= '0;
            res_valid_reg <= 1'b0;
            stg_pend_reg  <= 1'b0;
            stg_copy_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cursor_reg    <= cursor_next;
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;
            stg_pend_reg  <= stg_pend_next;
            stg_copy_reg  <= stg_copy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        op_reg        <= op_next;
        chr_reg       <= chr_next;
        attr_reg      <= attr_next;
        res_reg       <= res_next;
        stg_addr_reg  <= stg_addr_next;
        stg_blank_reg <= stg_blank_next;
    end

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(stg_pend_reg && dwe))
        else $error("staged and direct store writes collide");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CELLS_C)
        else $error("cursor beyond past-end position");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.scrolled |->
            (res_reg.cursor_pos == 11'(LAST_ROW_C)) ||
            (res_reg.cursor_pos == 11'(LAST_ROW_C + CW'(1))))
        else $error("scroll result with cursor off the last row start");

    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> stg_pend_reg)
        else $error("sweep ended without its last staged write");

endmodule

/* rtl/text_console_cell_engine.sv */
// Top level of the text console cell engine: config register, front end, queue, back end.
`timescale 1ns / 1ps

// channel | dir | handshake                  | payload
// item    | in  | item_valid / item_stall     | tcce_pkg::in_t
// result  | out | result_valid / result_stall | tcce_pkg::out_t
// config  | in  | psel penable pwrite pready  | clear_attribute at byte 0x0
//
// Put (cursor not past the end), backspace, set cursor and unused actions finish from idle
// in the back end; an in-range read adds a read state. Newline above the last row walks
// row starts; on the last row it scrolls. Scroll and clear sweep the whole store through
// its one write port; a put past the end writes its cell after the scroll sweep.
// Reset runs a pass that zeroes the store with item_stall high; config is taken.
// A two-entry command queue and the result register let either side stall on its own.

module text_console_cell_engine #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  tcce_pkg::in_t               item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tcce_pkg::out_t              result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [7:0]     clear_attr_reg, clear_attr_next;
    logic           cfg_write;
    logic           queue_full;
    logic           init_busy;
    logic           push;
    tcce_pkg::cmd_t push_cmd;
    logic           pop;
    logic           cmd_valid;
    tcce_pkg::cmd_t head_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        clear_attr_next = clear_attr_reg;
        if (cfg_write && (paddr[2] == tcce_pkg::REG_CLEAR_ATTR))
        begin
            clear_attr_next = pwdata[7:0];
        end
        prdata = '0;
        if (paddr[2] == tcce_pkg::REG_CLEAR_ATTR)
        begin
            prdata = {24'd0, clear_attr_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_attr_reg <= tcce_pkg::CLEAR_ATTR_RESET;
        end
        else
        begin
            clear_attr_reg <= clear_attr_next;
        end
    end

    tcce_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    tcce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .valid     (cmd_valid),
        .head      (head_cmd)
    );

    tcce_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear_attr   (clear_attr_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (head_cmd),
        .pop          (pop),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
